@@ design/vrt_pkg.sv @@
// Shared types and constants for the voxel ray traversal block.
// No dependencies; imported by vrt_div and the top level.
package vrt_pkg;

	localparam int TW    = 24;  // Q16.8 ray parameter width
	localparam int CELLW = 12;  // signed voxel index width during a walk
	localparam int DIRW  = 16;
	localparam int MAGW  = 17;  // direction magnitude, 32768 included
	localparam int QW    = 23;  // quotient width of 2^22 / magnitude
	localparam int DISTW = 9;   // distance to first boundary, Q1.8

	localparam logic [TW-1:0] T_INF = 24'hFFFFFF;
	localparam logic [15:0] REACH_RST = 16'd2048;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic [2:0] NO_FACE = 3'd0;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_SU_DIV,
		ST_SU_WAIT,
		ST_SU_MUL,
		ST_RD,
		ST_CHK,
		ST_STEP,
		ST_DONE
	} vrt_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ design/vrt_grid.sv @@
// Occupancy grid memory: one row of SIDE bits per (x, y) pair.
// Depends on nothing; read data is registered.
module vrt_grid #(
	parameter int SIDE   = 32,
	parameter int SIDE_W = 5
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [2*SIDE_W-1:0]   waddr,
	input  logic [SIDE-1:0]       wdata,
	input  logic [2*SIDE_W-1:0]   raddr,
	output logic [SIDE-1:0]       rdata
);

	logic [SIDE-1:0] mem [2**(2*SIDE_W)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ design/vrt_div.sv @@
// Bit-serial restoring divider computing 2^22 / divisor, one quotient bit a cycle.
// Depends on vrt_pkg for widths and the status struct.
module vrt_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [vrt_pkg::MAGW-1:0] divisor,
	output logic [vrt_pkg::QW-1:0]   quotient,
	output vrt_pkg::div_stat_t       stat
);
	import vrt_pkg::*;

	logic [MAGW-1:0] rem_q;
	logic [QW-1:0]   quo_q;
	logic [4:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [MAGW-1:0] sh;
	logic            qb;

	always_comb begin
		// dividend has a single set bit, the top one
		sh = {rem_q[MAGW-2:0], (cnt_q == 5'(QW - 1))};
		qb = (sh >= divisor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= qb ? (sh - divisor) : sh;
			quo_q <= {quo_q[QW-2:0], qb};
		end
	end

	assign quotient = quo_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

@@ design/voxel_ray_traversal.sv @@
// Voxel ray traversal top level: controller, set-up arithmetic and walk datapath.
// Depends on vrt_pkg, vrt_grid and vrt_div.
//
//  channel  | dir | words                                   | handshake
//  s_*      | in  | write or cast word (tuser = opcode)     | tvalid/tready
//  m_*      | out | cast result (tuser = hit)               | tvalid/tready
//  cfg_*    | in  | reach limit register                    | cfg_we only
//
// After reset the grid is swept clean, one row of GRID_SIDE bits a cycle, over all
// GRID_SIDE*GRID_SIDE rows (1024 at the default), with s_tready low.
// A write word reads its row, then modifies it and writes it back.
// A cast sets up the 3 axes in turn through the shared serial divider (ST_SU_DIV,
// ST_SU_WAIT) and a multiply step (ST_SU_MUL); zero components skip both. It then
// walks voxel by voxel (ST_CHK, ST_STEP), one grid memory read each, then hands over.
// One word is in flight at a time; the result register lets the next word
// in while a result still waits on m_tready.
module voxel_ray_traversal #(
	parameter int GRID_SIDE = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [4:0] cell_x, [9:5] cell_y, [14:10] cell_z, [15] cell_solid,
	// [31:16] origin_x, [47:32] origin_y, [63:48] origin_z,
	// [79:64] dir_x, [95:80] dir_y, [111:96] dir_z
	input  logic [111:0] s_tdata,
	// [0] opcode
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [4:0] hit_x, [9:5] hit_y, [14:10] hit_z, [17:15] hit_face, rest zero
	output logic [23:0]  m_tdata,
	// [0] hit
	output logic         m_tuser,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata
);
	import vrt_pkg::*;

	localparam int CW = $clog2(GRID_SIDE);
	localparam int AW = 2 * CW;

	vrt_state_t state_q, state_d;

	// configuration
	logic [15:0] reach_lim_q;

	// per-axis walk state
	logic signed [CELLW-1:0] cell_q   [3];
	logic                    neg_q    [3];
	logic [TW-1:0]           delta_q  [3];
	logic [TW-1:0]           tm_q     [3];
	logic [DIRW-1:0]         dir_q    [3];
	logic [7:0]              frac_q   [3];
	logic [1:0]              ax_q;
	logic [TW-1:0]           t_q;
	logic                    solid_q;
	logic [2:0]              face_q;
	logic                    ingrid_q;
	logic [CW-1:0]           zsel_q;
	logic [AW-1:0]           clr_q;

	// pending result
	logic       res_hit_q;
	logic [4:0] res_x_q, res_y_q, res_z_q;
	logic [2:0] res_face_q;

	// output register
	logic        m_tvalid_q;
	logic        m_hit_q;
	logic [17:0] m_data_q;

	// grid port
	logic            gr_we;
	logic [AW-1:0]   gr_waddr;
	logic [GRID_SIDE-1:0] gr_wdata;
	logic [AW-1:0]   gr_raddr;
	logic [GRID_SIDE-1:0] gr_rdata;

	// divider port
	logic            div_start;
	logic [MAGW-1:0] div_mag;
	logic [QW-1:0]   div_q;
	div_stat_t       div_st;

	// combinational helpers
	logic signed [CELLW-1:0] nc [3];
	logic [1:0]       sel_ax;
	logic             sel_inf;
	logic [TW:0]      tm_sum;
	logic [DISTW-1:0] gap;
	logic [DISTW+TW-1:0] prod;
	logic [TW-1:0]    tm_first;
	logic             ingrid_n;
	logic             cur_solid;
	logic             out_free;
	logic             accept;

	function automatic logic in_grid(input logic signed [CELLW-1:0] c);
		return !c[CELLW-1] && (c < CELLW'(GRID_SIDE));
	endfunction

	vrt_grid #(
		.SIDE   (GRID_SIDE),
		.SIDE_W (CW)
	) u_grid (
		.clk   (clk),
		.we    (gr_we),
		.waddr (gr_waddr),
		.wdata (gr_wdata),
		.raddr (gr_raddr),
		.rdata (gr_rdata)
	);

	vrt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (div_mag),
		.quotient (div_q),
		.stat     (div_st)
	);

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// pick the axis with the smallest next boundary; on a tie the higher axis wins
	always_comb begin
		if (tm_q[0] < tm_q[1]) begin
			sel_ax = (tm_q[0] < tm_q[2]) ? 2'd0 : 2'd2;
		end else begin
			sel_ax = (tm_q[1] < tm_q[2]) ? 2'd1 : 2'd2;
		end
		sel_inf = (tm_q[sel_ax] == T_INF);
		tm_sum  = {1'b0, tm_q[sel_ax]} + {1'b0, delta_q[sel_ax]};
	end

	// next cells: the stepped voxel during a step, else the held ones
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nc[i] = cell_q[i];
		end
		if (state_q == ST_STEP && !sel_inf) begin
			nc[sel_ax] = neg_q[sel_ax] ? cell_q[sel_ax] - CELLW'(1)
			                           : cell_q[sel_ax] + CELLW'(1);
		end
		ingrid_n = in_grid(nc[0]) && in_grid(nc[1]) && in_grid(nc[2]);
		gr_raddr = {nc[0][CW-1:0], nc[1][CW-1:0]};
	end

	// set-up arithmetic for the current axis
	always_comb begin
		div_mag = dir_q[ax_q][DIRW-1] ? (MAGW'(0) - {1'b1, dir_q[ax_q]})
		                              : {1'b0, dir_q[ax_q]};
		gap = dir_q[ax_q][DIRW-1] ? {1'b0, frac_q[ax_q]}
		                          : DISTW'(256) - {1'b0, frac_q[ax_q]};
		prod = (DISTW+TW)'(gap) * (DISTW+TW)'(delta_q[ax_q]);
		tm_first = (prod[DISTW+TW-1:TW+8] != '0) ? T_INF : prod[TW+7:8];
		div_start = (state_q == ST_SU_DIV) && (dir_q[ax_q] != '0);
	end

	assign cur_solid = ingrid_q && gr_rdata[zsel_q];

	// grid writes: clearing sweep or read-modify-write of one row
	always_comb begin
		gr_we    = 1'b0;
		gr_waddr = {cell_q[0][CW-1:0], cell_q[1][CW-1:0]};
		gr_wdata = gr_rdata;
		gr_wdata[cell_q[2][CW-1:0]] = solid_q;
		if (state_q == ST_CLR) begin
			gr_we    = 1'b1;
			gr_waddr = clr_q;
			gr_wdata = '0;
		end else if (state_q == ST_WR_WB) begin
			gr_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = (s_tuser == OP_CAST) ? ST_SU_DIV : ST_WR_RD;
			end
			ST_WR_RD: begin
				state_d = ingrid_n ? ST_WR_WB : ST_IDLE;
			end
			ST_WR_WB: begin
				state_d = ST_IDLE;
			end
			ST_SU_DIV: begin
				if (dir_q[ax_q] != '0) state_d = ST_SU_WAIT;
				else if (ax_q == 2'd2) state_d = ST_RD;
			end
			ST_SU_WAIT: begin
				if (div_st.done) state_d = ST_SU_MUL;
			end
			ST_SU_MUL: begin
				state_d = (ax_q == 2'd2) ? ST_RD : ST_SU_DIV;
			end
			ST_RD: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (cur_solid || t_q > TW'(reach_lim_q)) state_d = ST_DONE;
				else state_d = ST_STEP;
			end
			ST_STEP: begin
				state_d = sel_inf ? ST_DONE : ST_CHK;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			reach_lim_q <= REACH_RST;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (state_q == ST_CLR) clr_q <= clr_q + AW'(1);
			if (cfg_we) reach_lim_q <= cfg_wdata;
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		ingrid_q <= ingrid_n;
		zsel_q   <= nc[2][CW-1:0];
		if (accept) begin
			// latch the word: write index or ray start cell, plus solid bit, direction and fraction
			ax_q    <= 2'd0;
			t_q     <= '0;
			face_q  <= NO_FACE;
			solid_q <= s_tdata[15];
			for (int i = 0; i < 3; i++) begin
				dir_q[i]  <= s_tdata[64+16*i +: 16];
				frac_q[i] <= s_tdata[16+16*i +: 8];
				neg_q[i]  <= !(s_tdata[64+16*i +: 16] != '0 && !s_tdata[79+16*i]);
				if (s_tuser == OP_CAST) begin
					cell_q[i] <= CELLW'($signed(s_tdata[24+16*i +: 8]));
				end else begin
					cell_q[i] <= CELLW'(s_tdata[5*i +: 5]);
				end
			end
		end
		case (state_q)
			ST_SU_DIV: begin
				if (dir_q[ax_q] == '0) begin
					delta_q[ax_q] <= T_INF;
					tm_q[ax_q]    <= T_INF;
					ax_q          <= ax_q + 2'd1;
				end
			end
			ST_SU_WAIT: begin
				if (div_st.done) delta_q[ax_q] <= TW'(div_q);
			end
			ST_SU_MUL: begin
				tm_q[ax_q] <= tm_first;
				ax_q       <= ax_q + 2'd1;
			end
			ST_CHK: begin
				// hold a hit, or a miss once t has run past the reach
				res_hit_q  <= cur_solid;
				res_x_q    <= cur_solid ? cell_q[0][4:0] : 5'd0;
				res_y_q    <= cur_solid ? cell_q[1][4:0] : 5'd0;
				res_z_q    <= cur_solid ? cell_q[2][4:0] : 5'd0;
				res_face_q <= cur_solid ? face_q : NO_FACE;
			end
			ST_STEP: begin
				if (sel_inf) begin
					res_hit_q  <= 1'b0;
					res_x_q    <= 5'd0;
					res_y_q    <= 5'd0;
					res_z_q    <= 5'd0;
					res_face_q <= NO_FACE;
				end else begin
					cell_q[sel_ax] <= nc[sel_ax];
					t_q            <= tm_q[sel_ax];
					tm_q[sel_ax]   <= tm_sum[TW] ? T_INF : tm_sum[TW-1:0];
					face_q         <= {sel_ax, 1'b0} + (neg_q[sel_ax] ? 3'd2 : 3'd1);
				end
			end
			default: ;
		endcase
		if (state_q == ST_DONE && out_free) begin
			m_hit_q  <= res_hit_q;
			m_data_q <= {res_face_q, res_z_q, res_y_q, res_x_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_hit_q;
	assign m_tdata  = {6'd0, m_data_q};

`ifndef SYNTHESIS
	// no word taken while the grid is still being swept
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !s_tready)
		else $error("word accepted during grid clear");

	// the grid is written only by the sweep or a write word
	assert property (@(posedge clk) disable iff (!arst_n)
		gr_we |-> (state_q == ST_CLR || state_q == ST_WR_WB))
		else $error("stray grid write");

	// a miss carries all-zero coordinates and face
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("miss with non-zero payload");

	// face code stays within the defined set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[17:15] <= 3'd6))
		else $error("face code out of range");

	// the divider is only started when idle
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider restarted while busy");
`endif

endmodule
